FILE: rtl/core/multi_stream_timestamp_matcher_defines.svh
// Assertion macros for the timestamp matcher checker.
// No dependencies; included by the checker file.
`ifndef MULTI_STREAM_TIMESTAMP_MATCHER_DEFINES_SVH
`define MULTI_STREAM_TIMESTAMP_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MSTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/msts_pkg.sv
// Shared types and constants of the timestamp matcher.
// No dependencies; used by the top level and the checker.
package msts_pkg;

    localparam int WEEK_W   = 15;
    localparam int MS_W     = 30;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 5;
    localparam int STREAMS  = 3;

    localparam logic [MS_W-1:0]    WEEK_MS_LIMIT = 30'd604800000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 5'd16;
    localparam logic [STREAMS-1:0] ALL_PRESENT   = 3'b111;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_EVICT,
        S_RESULT
    } state_t;

endpackage

FILE: rtl/core/multi_stream_timestamp_matcher.sv
// Top level of the multi-stream timestamp matcher: sequencer around the entry table.
// Depends on msts_pkg and msts_table_ram.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid/in_ready, kind..payload_handle    | request in
//  out     | out_valid/out_ready, status..match_*       | result out
//  cfg     | cfg_we, cfg_wdata (history_limit)          | write only
//
// Sequence: a request scans the table with a read state and a check state per entry;
// an add then merges its stream in place or writes a new entry, then evicts if needed,
// and a new time inserted in the middle first moves each later entry up with a read state
// and a write state. The registered read of the single read port paces scan and shift.
// Reset: rst_n clears the table count, head pointer and result valid, and loads the
// limit with 16; no clearing pass.
// Stalls: one finished result waits in the output register while the next request
// is taken; the sequencer holds in its result state only if that register is still full.
module multi_stream_timestamp_matcher #(
    parameter int TABLE_DEPTH  = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [1:0]                     stream_id,
    input  logic [msts_pkg::WEEK_W-1:0]    gps_week,
    input  logic [msts_pkg::MS_W-1:0]      week_ms,
    input  logic [HANDLE_WIDTH-1:0]        payload_handle,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [msts_pkg::STATUS_W-1:0]  status,
    output logic                           evicted,
    output logic [msts_pkg::WEEK_W-1:0]    match_week,
    output logic [msts_pkg::MS_W-1:0]      match_ms,
    output logic [HANDLE_WIDTH-1:0]        match_obs_handle,
    output logic [HANDLE_WIDTH-1:0]        match_corr_handle,
    output logic [HANDLE_WIDTH-1:0]        match_vrs_handle,
    input  logic                           cfg_we,
    input  logic [msts_pkg::LIMIT_W-1:0]   cfg_wdata
);

    // One spare slot absorbs the new entry of a full table before eviction.
    localparam int SLOTS = TABLE_DEPTH + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(TABLE_DEPTH + 2);
    localparam int SW    = CW + 1;
    localparam int HW    = HANDLE_WIDTH;
    localparam int KEY_W = msts_pkg::WEEK_W + msts_pkg::MS_W;

    // Entry layout: week | ms | present | vrs | corr | obs
    localparam int P_LSB  = msts_pkg::STREAMS * HW;
    localparam int MS_LSB = P_LSB + msts_pkg::STREAMS;
    localparam int WK_LSB = MS_LSB + msts_pkg::MS_W;
    localparam int EW     = WK_LSB + msts_pkg::WEEK_W;

    // Map a logical position (0 = oldest) onto the circular slot array.
    function automatic logic [AW-1:0] phys_f(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(i);
        if (sum >= SW'(SLOTS))
        begin
            sum = sum - SW'(SLOTS);
        end
        return sum[AW-1:0];
    endfunction

    msts_pkg::state_t state_reg, state_next;

    logic                          kind_reg;
    logic [1:0]                    sid_reg;
    logic [msts_pkg::WEEK_W-1:0]   week_reg;
    logic [msts_pkg::MS_W-1:0]     ms_reg;
    logic [HW-1:0]                 handle_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [msts_pkg::LIMIT_W-1:0] limit_reg;

    logic [msts_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          res_evicted_reg, res_evicted_next;
    logic [msts_pkg::WEEK_W-1:0]   res_week_reg, res_week_next;
    logic [msts_pkg::MS_W-1:0]     res_ms_reg, res_ms_next;
    logic [P_LSB-1:0]              res_handles_reg, res_handles_next;

    logic                          out_valid_reg;
    logic [msts_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_evicted_reg;
    logic [msts_pkg::WEEK_W-1:0]   out_week_reg;
    logic [msts_pkg::MS_W-1:0]     out_ms_reg;
    logic [P_LSB-1:0]              out_handles_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic                          accept;
    logic                          load_out;
    logic [msts_pkg::STREAMS-1:0]  bit_mask;
    logic [msts_pkg::STREAMS-1:0]  rd_present;
    logic [KEY_W-1:0]              rd_key, item_key;
    logic [P_LSB-1:0]              rd_handles, merged_handles, fresh_handles;
    logic [CW-1:0]                 eff_limit;
    logic [CW-1:0]                 idx_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == msts_pkg::S_IDLE);
    assign load_out = (state_reg == msts_pkg::S_RESULT) && (!out_valid_reg || out_ready);

    assign bit_mask   = msts_pkg::STREAMS'(1) << sid_reg;
    assign rd_present = ram_rdata[MS_LSB-1:P_LSB];
    assign rd_handles = ram_rdata[P_LSB-1:0];
    assign rd_key     = ram_rdata[EW-1:MS_LSB];
    assign item_key   = {week_reg, ms_reg};
    assign idx_inc    = idx_reg + CW'(1);

    // Clamp the configured limit to the table depth.
    assign eff_limit = (32'(limit_reg) >= TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                       : CW'(limit_reg);

    // Drop the sample's handle into its stream slot, on the read entry or a fresh one.
    always_comb
    begin
        merged_handles = rd_handles;
        fresh_handles  = '0;
        for (int s = 0; s < msts_pkg::STREAMS; s++)
        begin
            if (sid_reg == 2'(s))
            begin
                merged_handles[s*HW +: HW] = handle_reg;
                fresh_handles[s*HW +: HW]  = handle_reg;
            end
        end
    end

    msts_table_ram #(
        .SLOTS (SLOTS),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msts_pkg::S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            limit_reg     <= msts_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        res_status_reg  <= res_status_next;
        res_evicted_reg <= res_evicted_next;
        res_week_reg    <= res_week_next;
        res_ms_reg      <= res_ms_next;
        res_handles_reg <= res_handles_next;
        if (accept)
        begin
            kind_reg   <= kind;
            sid_reg    <= stream_id;
            week_reg   <= gps_week;
            ms_reg     <= week_ms;
            handle_reg <= payload_handle;
        end
        if (load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_evicted_reg <= res_evicted_reg;
            out_week_reg    <= res_week_reg;
            out_ms_reg      <= res_ms_reg;
            out_handles_reg <= res_handles_reg;
        end
    end

    // Sequencer. Each memory access is issued in its own state, so a write never
    // overlaps a used read of the same slot and no forwarding is needed.
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        res_status_next  = res_status_reg;
        res_evicted_next = res_evicted_reg;
        res_week_next    = res_week_reg;
        res_ms_next      = res_ms_reg;
        res_handles_next = res_handles_reg;
        ram_we           = 1'b0;
        ram_waddr        = phys_f(head_reg, idx_reg);
        ram_wdata        = ram_rdata;
        ram_raddr        = phys_f(head_reg, idx_reg);

        unique case (state_reg)
            msts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_evicted_next = 1'b0;
                    res_week_next    = '0;
                    res_ms_next      = '0;
                    res_handles_next = '0;
                    idx_next         = '0;
                    pos_next         = '0;
                    if (kind == msts_pkg::KIND_FIND)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = msts_pkg::ST_NO_MATCH;
                            state_next      = msts_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = msts_pkg::S_SCAN_RD;
                        end
                    end
                    else if (week_ms >= msts_pkg::WEEK_MS_LIMIT || stream_id == 2'd3)
                    begin
                        res_status_next = msts_pkg::ST_INVALID;
                        state_next      = msts_pkg::S_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = msts_pkg::S_INSERT;
                    end
                    else
                    begin
                        state_next = msts_pkg::S_SCAN_RD;
                    end
                end
            end

            msts_pkg::S_SCAN_RD:
            begin
                state_next = msts_pkg::S_SCAN_CK;
            end

            msts_pkg::S_SCAN_CK:
            begin
                if (kind_reg == msts_pkg::KIND_FIND)
                begin
                    if (rd_present == msts_pkg::ALL_PRESENT)
                    begin
                        // Return the match and drop it with every older entry.
                        res_status_next  = msts_pkg::ST_MATCH;
                        res_week_next    = ram_rdata[EW-1:WK_LSB];
                        res_ms_next      = ram_rdata[WK_LSB-1:MS_LSB];
                        res_handles_next = rd_handles;
                        head_next        = phys_f(head_reg, idx_inc);
                        count_next       = count_reg - idx_inc;
                        state_next       = msts_pkg::S_RESULT;
                    end
                    else if (idx_inc == count_reg)
                    begin
                        res_status_next = msts_pkg::ST_NO_MATCH;
                        state_next      = msts_pkg::S_RESULT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = msts_pkg::S_SCAN_RD;
                    end
                end
                else if (rd_key == item_key)
                begin
                    if ((rd_present & bit_mask) != '0)
                    begin
                        res_status_next = msts_pkg::ST_DUP;
                        state_next      = msts_pkg::S_RESULT;
                    end
                    else
                    begin
                        // Merge the stream into the existing entry in place.
                        ram_we          = 1'b1;
                        ram_wdata       = {rd_key, rd_present | bit_mask, merged_handles};
                        res_status_next = msts_pkg::ST_STORED;
                        state_next      = msts_pkg::S_EVICT;
                    end
                end
                else if (rd_key > item_key)
                begin
                    // Newer entry found: open a gap here by moving the tail up.
                    pos_next   = idx_reg;
                    idx_next   = count_reg - CW'(1);
                    state_next = msts_pkg::S_SHIFT_RD;
                end
                else if (idx_inc == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = msts_pkg::S_INSERT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = msts_pkg::S_SCAN_RD;
                end
            end

            msts_pkg::S_SHIFT_RD:
            begin
                state_next = msts_pkg::S_SHIFT_WR;
            end

            msts_pkg::S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys_f(head_reg, idx_inc);
                ram_wdata = ram_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = msts_pkg::S_INSERT;
                end
                else
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = msts_pkg::S_SHIFT_RD;
                end
            end

            msts_pkg::S_INSERT:
            begin
                ram_we          = 1'b1;
                ram_waddr       = phys_f(head_reg, pos_reg);
                ram_wdata       = {item_key, bit_mask, fresh_handles};
                count_next      = count_reg + CW'(1);
                res_status_next = msts_pkg::ST_STORED;
                state_next      = msts_pkg::S_EVICT;
            end

            msts_pkg::S_EVICT:
            begin
                if (count_reg > eff_limit)
                begin
                    head_next        = phys_f(head_reg, count_reg - eff_limit);
                    count_next       = eff_limit;
                    res_evicted_next = 1'b1;
                end
                state_next = msts_pkg::S_RESULT;
            end

            msts_pkg::S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = msts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = msts_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign evicted           = out_evicted_reg;
    assign match_week        = out_week_reg;
    assign match_ms          = out_ms_reg;
    assign match_obs_handle  = out_handles_reg[HW-1:0];
    assign match_corr_handle = out_handles_reg[2*HW-1:HW];
    assign match_vrs_handle  = out_handles_reg[3*HW-1:2*HW];

endmodule

FILE: rtl/core/msts_table_ram.sv
// Entry table memory: one write port, one read port, registered read data.
// No dependencies.
module msts_table_ram #(
    parameter int SLOTS = 17,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [SLOTS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/msts_checker.sv
// Port-level checker of the timestamp matcher, bound to the top level.
// Depends on msts_pkg and multi_stream_timestamp_matcher_defines.svh.
`include "multi_stream_timestamp_matcher_defines.svh"

module msts_checker #(
    parameter int TABLE_DEPTH  = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          kind,
    input logic [1:0]                    stream_id,
    input logic [msts_pkg::WEEK_W-1:0]   gps_week,
    input logic [msts_pkg::MS_W-1:0]     week_ms,
    input logic [HANDLE_WIDTH-1:0]       payload_handle,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [msts_pkg::STATUS_W-1:0] status,
    input logic                          evicted,
    input logic [msts_pkg::WEEK_W-1:0]   match_week,
    input logic [msts_pkg::MS_W-1:0]     match_ms,
    input logic [HANDLE_WIDTH-1:0]       match_obs_handle,
    input logic [HANDLE_WIDTH-1:0]       match_corr_handle,
    input logic [HANDLE_WIDTH-1:0]       match_vrs_handle,
    input logic                          cfg_we,
    input logic [msts_pkg::LIMIT_W-1:0]  cfg_wdata
);

    logic match_zero;
    logic match_ms_ok;

    assign match_zero  = match_week == '0 && match_ms == '0 && match_obs_handle == '0
                         && match_corr_handle == '0 && match_vrs_handle == '0;
    assign match_ms_ok = match_ms < msts_pkg::WEEK_MS_LIMIT;

    // Hold a stalled result.
    `MSTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

    // The block is busy in the cycle after taking a request.
    `MSTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // Only a stored add may report an eviction.
    `MSTS_ASSERT_NOW(a_evict_only_stored, out_valid && evicted, status == msts_pkg::ST_STORED)

    // Non-match results carry zero match fields.
    `MSTS_ASSERT_NOW(a_zero_fields, out_valid && status != msts_pkg::ST_MATCH, match_zero)

    // A returned match time is a valid time of week.
    `MSTS_ASSERT_NOW(a_match_time, out_valid && status == msts_pkg::ST_MATCH, match_ms_ok)

endmodule

bind multi_stream_timestamp_matcher msts_checker #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
) u_msts_checker (.*);
